>>> rtl/core/psps_pkg.sv
// Shared types, constants and helpers for the particle step block.
// Used by psps_update, psps_fitness and the top module; depends on nothing.
package psps_pkg;

    localparam int MAX_DIMENSIONS = 32;
    localparam int POS_MARGIN     = 66;
    localparam int ROSEN_GAIN     = 100;
    localparam int ONE_Q16        = 65536;
    localparam int CFG_DATA_W     = 32;

    localparam logic [63:0] ALL_ONES64  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ROSEN_LIMIT = ALL_ONES64 / 64'(ROSEN_GAIN);
    localparam logic [63:0] LOW32_MAX   = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_INERTIA   = 3'd0,
        REG_COGNITIVE = 3'd1,
        REG_SOCIAL    = 3'd2,
        REG_VLIMIT    = 3'd3,
        REG_UPPER     = 3'd4,
        REG_LOWER     = 3'd5,
        REG_FITKIND   = 3'd6,
        REG_DIMS      = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_VEL,
        ST_POS,
        ST_FSQ,
        ST_FDIF,
        ST_FPRD,
        ST_FSAT,
        ST_FTERM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] global_best_pos;
        logic [15:0]        rand_cognitive;
        logic [15:0]        rand_social;
        logic signed [31:0] load_pos;
        logic signed [31:0] load_vel;
    } in_word_t;

    typedef struct packed {
        logic [4:0]         dim_index;
        logic signed [31:0] new_pos;
        logic signed [31:0] new_vel;
        logic               last_dim;
        logic [63:0]        fitness;
        logic               improved;
        logic [63:0]        best_fitness_out;
    } out_word_t;

    typedef struct packed {
        logic [15:0]        inertia_weight;
        logic [15:0]        cognitive_gain;
        logic [15:0]        social_gain;
        logic [30:0]        velocity_limit;
        logic signed [31:0] upper_bound;
        logic signed [31:0] lower_bound;
    } motion_cfg_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES64 : s[63:0];
    endfunction

endpackage

>>> rtl/core/psps_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No package dependencies.
module psps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> rtl/core/psps_update.sv
// Velocity and position update pipeline, sequenced by the top-level state.
// Depends on psps_pkg.
module psps_update (
    input  logic                 aclk,
    input  psps_pkg::state_t     state,
    input  psps_pkg::in_word_t   in_word,
    input  psps_pkg::motion_cfg_t cfg,
    input  logic signed [31:0]   x,
    input  logic signed [31:0]   v,
    input  logic signed [31:0]   pb,
    output logic signed [31:0]   np_reg,
    output logic signed [31:0]   nv_reg
);
    import psps_pkg::*;

    logic [15:0]        k1_reg, k2_reg;
    logic signed [48:0] t0_reg;
    logic signed [49:0] t1_reg, t2_reg;
    logic signed [31:0] vc_reg;

    logic [31:0]        kp1, kp2;
    logic signed [16:0] iw_s, k1_s, k2_s;
    logic signed [32:0] dpb, dgb;
    logic signed [48:0] t0_next;
    logic signed [49:0] t1_next, t2_next;
    logic signed [37:0] vsum, vm;
    logic signed [31:0] vc_next;
    logic signed [33:0] np_w, ub_w, lb_w;
    logic signed [31:0] nv_w, np_next, nv_next;

    always_comb begin
        kp1 = cfg.cognitive_gain * in_word.rand_cognitive;
        kp2 = cfg.social_gain * in_word.rand_social;
        iw_s = signed'({1'b0, cfg.inertia_weight});
        k1_s = signed'({1'b0, k1_reg});
        k2_s = signed'({1'b0, k2_reg});
        dpb = 33'(pb) - 33'(x);
        dgb = 33'(in_word.global_best_pos) - 33'(x);
        t0_next = 49'(v) * 49'(iw_s);
        t1_next = 50'(dpb) * 50'(k1_s);
        t2_next = 50'(dgb) * 50'(k2_s);
        vsum = 38'(t0_reg >>> 14) + 38'(t1_reg >>> 14) + 38'(t2_reg >>> 14);
        vm = signed'({7'b0, cfg.velocity_limit});
        if (vsum < -vm) begin
            vc_next = vsum[31:0] ^ vsum[31:0] ^ (-vm[31:0]);
        end else if (vsum > vm) begin
            vc_next = vm[31:0];
        end else begin
            vc_next = vsum[31:0];
        end
        np_w = 34'(x) + 34'(vc_reg);
        nv_w = vc_reg;
        ub_w = 34'(cfg.upper_bound);
        lb_w = 34'(cfg.lower_bound);
        if (np_w > ub_w) begin
            np_w = ub_w - 34'(POS_MARGIN);
            nv_w = '0;
        end
        if (np_w < lb_w) begin
            np_w = lb_w + 34'(POS_MARGIN);
            nv_w = '0;
        end
        if (np_w > 34'sh0_7FFF_FFFF) begin
            np_w = 34'sh0_7FFF_FFFF;
        end
        if (np_w < -34'sh0_8000_0000) begin
            np_w = -34'sh0_8000_0000;
        end
        if (in_word.mode) begin
            np_next = in_word.load_pos;
            nv_next = in_word.load_vel;
        end else begin
            np_next = np_w[31:0];
            nv_next = nv_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (state == ST_RD) begin
            k1_reg <= kp1[31:16];
            k2_reg <= kp2[31:16];
        end
        if (state == ST_MUL) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
        end
        if (state == ST_VEL) begin
            vc_reg <= vc_next;
        end
        if (state == ST_POS) begin
            np_reg <= np_next;
            nv_reg <= nv_next;
        end
    end

endmodule

>>> rtl/core/psps_fitness.sv
// Per-dimension fitness term: sum of squares or Rosenbrock valley, saturating.
// Depends on psps_pkg.
module psps_fitness (
    input  logic               aclk,
    input  psps_pkg::state_t   state,
    input  logic               fit_kind,
    input  logic               first_dim,
    input  logic signed [31:0] np,
    input  logic signed [31:0] prev_pos,
    output logic [63:0]        term_reg
);
    import psps_pkg::*;

    logic [63:0]        sq_reg, mag_reg, uu_reg, hh_reg, cross_reg, ll_reg, t_reg;
    logic [32:0]        umag_reg;

    logic signed [31:0] sq_op;
    logic signed [63:0] sq_next, diff;
    logic signed [33:0] u;
    logic [32:0]        umag_next;
    logic [65:0]        uu_full;
    logic [63:0]        t_next, t100, term_next;

    always_comb begin
        sq_op = fit_kind ? prev_pos : np;
        sq_next = 64'(sq_op) * 64'(sq_op);
        u = 34'(ONE_Q16) - 34'(prev_pos);
        umag_next = u[33] ? 33'(-u) : u[32:0];
        diff = signed'({{16{np[31]}}, np, 16'b0}) - signed'(sq_reg);
        uu_full = 66'(umag_reg) * 66'(umag_reg);
        if (hh_reg > LOW32_MAX) begin
            t_next = ALL_ONES64;
        end else begin
            t_next = sat_add(sat_add(sat_add({hh_reg[31:0], 32'b0}, cross_reg), cross_reg),
                             {32'b0, ll_reg[63:32]});
        end
        t100 = (t_reg > ROSEN_LIMIT) ? ALL_ONES64 : t_reg * 64'(ROSEN_GAIN);
        if (!fit_kind) begin
            term_next = sq_reg;
        end else if (first_dim) begin
            term_next = '0;
        end else begin
            term_next = sat_add(t100, uu_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state == ST_FSQ) begin
            sq_reg   <= sq_next;
            umag_reg <= umag_next;
        end
        if (state == ST_FDIF) begin
            mag_reg <= diff[63] ? 64'(-diff) : 64'(diff);
            uu_reg  <= uu_full[63:0];
        end
        if (state == ST_FPRD) begin
            hh_reg    <= mag_reg[63:32] * mag_reg[63:32];
            cross_reg <= mag_reg[63:32] * mag_reg[31:0];
            ll_reg    <= mag_reg[31:0] * mag_reg[31:0];
        end
        if (state == ST_FSAT) begin
            t_reg <= t_next;
        end
        if (state == ST_FTERM) begin
            term_reg <= term_next;
        end
    end

endmodule

>>> rtl/core/particle_swarm_particle_step_top.sv
// Particle step top: a multi-cycle sequencer steps each word through the update and
// fitness stages to the result register; a new word is taken only back in ST_IDLE.
// Result register frees the input side: the next word is taken while a result waits.
// Synchronous active-low reset clears config to defaults, best fitness to all ones,
// running sum, previous position and dimension counter to zero. Stores are not cleared.
// Depends on psps_pkg, psps_ram, psps_update, psps_fitness.
module particle_swarm_particle_step_top #(
    parameter int MAX_DIM = psps_pkg::MAX_DIMENSIONS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  psps_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output psps_pkg::out_word_t                 m_data,
    input  logic                                cfg_wr_en,
    input  psps_pkg::cfg_index_t                cfg_index,
    input  logic [psps_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import psps_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int RW = AW + 1;

    state_t state_reg, state_next;
    motion_cfg_t mcfg_reg;
    logic        fit_kind_reg;
    logic [5:0]  dims_reg;
    in_word_t    in_reg;
    out_word_t   out_reg, out_next;
    logic        m_valid_reg;
    logic [63:0] best_reg, run_reg;
    logic signed [31:0] prev_reg;
    logic [AW-1:0] dcnt_reg;
    logic [MAX_DIM-1:0] cur_reg, same_reg;

    logic          rd_en, fin_go;
    logic [RW-1:0] pos_ra, pb_ra, pos_wa;
    logic          wbank;
    logic signed [31:0] x, v, pb, np, nv;
    logic [63:0]   term, sum_new;
    logic [CW-1:0] cnt;
    logic          last, improve;

    psps_ram #(.WIDTH(32), .DEPTH(2 * MAX_DIM)) u_pos_ram (
        .aclk(aclk), .wr_en(fin_go), .wr_addr(pos_wa), .wr_data(np),
        .rd_en(rd_en), .rd_addr_a(pos_ra), .rd_addr_b(pb_ra),
        .rd_data_a(x), .rd_data_b(pb)
    );

    psps_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_vel_ram (
        .aclk(aclk), .wr_en(fin_go), .wr_addr(dcnt_reg), .wr_data(nv),
        .rd_en(rd_en), .rd_addr_a(dcnt_reg), .rd_addr_b(dcnt_reg),
        .rd_data_a(v), .rd_data_b()
    );

    psps_update u_update (
        .aclk(aclk), .state(state_reg), .in_word(in_reg), .cfg(mcfg_reg),
        .x(x), .v(v), .pb(pb), .np_reg(np), .nv_reg(nv)
    );

    psps_fitness u_fitness (
        .aclk(aclk), .state(state_reg), .fit_kind(fit_kind_reg),
        .first_dim(dcnt_reg == '0), .np(np), .prev_pos(prev_reg), .term_reg(term)
    );

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  state_next = s_valid ? ST_RD : ST_IDLE;
            ST_RD:    state_next = ST_MUL;
            ST_MUL:   state_next = ST_VEL;
            ST_VEL:   state_next = ST_POS;
            ST_POS:   state_next = ST_FSQ;
            ST_FSQ:   state_next = ST_FDIF;
            ST_FDIF:  state_next = ST_FPRD;
            ST_FPRD:  state_next = ST_FSAT;
            ST_FSAT:  state_next = ST_FTERM;
            ST_FTERM: state_next = ST_FIN;
            ST_FIN:   state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        rd_en   = s_valid && s_ready;
        fin_go  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        pos_ra = {cur_reg[dcnt_reg], dcnt_reg};
        pb_ra  = {same_reg[dcnt_reg] ? cur_reg[dcnt_reg] : ~cur_reg[dcnt_reg], dcnt_reg};
        wbank  = (!in_reg.mode && same_reg[dcnt_reg]) ? ~cur_reg[dcnt_reg] : cur_reg[dcnt_reg];
        pos_wa = {wbank, dcnt_reg};
        if (dims_reg == '0) begin
            cnt = CW'(1);
        end else if (dims_reg > MAX_DIM) begin
            cnt = CW'(MAX_DIM);
        end else begin
            cnt = CW'(dims_reg);
        end
        last    = (32'(dcnt_reg) + 32'd1) >= 32'(cnt);
        sum_new = sat_add(run_reg, term);
        improve = last && (in_reg.mode || (sum_new < best_reg));
        out_next.dim_index        = 5'(dcnt_reg);
        out_next.new_pos          = np;
        out_next.new_vel          = nv;
        out_next.last_dim         = last;
        out_next.fitness          = last ? sum_new : '0;
        out_next.improved         = improve;
        out_next.best_fitness_out = improve ? sum_new : best_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            best_reg     <= ALL_ONES64;
            run_reg      <= '0;
            prev_reg     <= '0;
            dcnt_reg     <= '0;
            cur_reg      <= '0;
            same_reg     <= '0;
            mcfg_reg.inertia_weight <= 16'd11469;
            mcfg_reg.cognitive_gain <= 16'd32768;
            mcfg_reg.social_gain    <= 16'd32768;
            mcfg_reg.velocity_limit <= 31'd655360;
            mcfg_reg.upper_bound    <= 32'sd655360;
            mcfg_reg.lower_bound    <= -32'sd655360;
            fit_kind_reg <= 1'b0;
            dims_reg     <= 6'd10;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_INERTIA:   mcfg_reg.inertia_weight <= cfg_wr_data[15:0];
                    REG_COGNITIVE: mcfg_reg.cognitive_gain <= cfg_wr_data[15:0];
                    REG_SOCIAL:    mcfg_reg.social_gain    <= cfg_wr_data[15:0];
                    REG_VLIMIT:    mcfg_reg.velocity_limit <= cfg_wr_data[30:0];
                    REG_UPPER:     mcfg_reg.upper_bound    <= cfg_wr_data;
                    REG_LOWER:     mcfg_reg.lower_bound    <= cfg_wr_data;
                    REG_FITKIND:   fit_kind_reg            <= cfg_wr_data[0];
                    REG_DIMS:      dims_reg                <= cfg_wr_data[5:0];
                    default:       fit_kind_reg            <= fit_kind_reg;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fin_go) begin
                m_valid_reg <= 1'b1;
                prev_reg    <= np;
                best_reg    <= out_next.best_fitness_out;
                if (last) begin
                    run_reg  <= '0;
                    dcnt_reg <= '0;
                end else begin
                    run_reg  <= sum_new;
                    dcnt_reg <= dcnt_reg + AW'(1);
                end
                cur_reg[dcnt_reg]  <= wbank;
                same_reg[dcnt_reg] <= in_reg.mode;
                if (improve && !in_reg.mode) begin
                    for (int i = 0; i < MAX_DIM; i++) begin
                        if (i < 32'(cnt)) begin
                            same_reg[i] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            in_reg <= s_data;
        end
        if (fin_go) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
